@@ src/e2c_pkg.sv @@
// Shared constants, types and tables for the epoch-to-calendar pipeline.
// No dependencies; imported by every module of the block.
package e2c_pkg;

    localparam int NUM_STAGES = 15;

    typedef logic [NUM_STAGES:1] stage_en_t;

    // Bias that makes every input non-negative: 11150 whole 400-year eras in seconds.
    localparam logic [48:0] EPOCH_OFFSET  = 49'd140744005920000;
    localparam logic [14:0] ERA_BIAS      = 15'd11150;
    localparam logic [13:0] REBASE_DAYS   = 14'd11017;

    // 86400 = 675 * 128; the 128 part is a shift.
    localparam logic [9:0]  DIV_675       = 10'd675;
    localparam logic [31:0] RECIP_675     = 32'd3257812230;   // floor(2^41 / 675)

    localparam logic [17:0] D400          = 18'd146097;
    localparam logic [14:0] RECIP_D400    = 15'd29398;        // floor(2^32 / 146097)
    localparam logic [15:0] D100          = 16'd36524;
    localparam logic [10:0] D4            = 11'd1461;
    localparam logic [5:0]  RECIP_D4      = 6'd44;            // floor(2^16 / 1461)
    localparam logic [8:0]  D1            = 9'd365;

    localparam logic [5:0]  SIXTY         = 6'd60;
    localparam logic [11:0] RECIP_60_SOD  = 12'd2184;         // floor(2^17 / 60)
    localparam logic [5:0]  RECIP_60_MOD  = 6'd34;            // floor(2^11 / 60)

    localparam logic [5:0]  ERA_WDAY      = 6'd3;             // 2000-03-01 is a Wednesday
    localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;
    localparam logic [8:0]  MAR1_YDAY     = 9'd59;
    localparam logic [23:0] ERA_YEARS     = 24'd400;
    localparam logic [23:0] CENTURY_YEARS = 24'd100;
    // 400 * ERA_BIAS - (2000 - 1900)
    localparam logic [23:0] YEAR_BIAS     = 24'd4459900;
    localparam logic [3:0]  MONTH_WRAP    = 4'd10;
    localparam logic [3:0]  MONTHS_TO_JAN = 4'd2;

    typedef struct packed {
        logic [14:0] q400;
        logic [1:0]  c100;
        logic [4:0]  c4;
        logic [1:0]  c1;
        logic [8:0]  d1;
        logic [2:0]  wday;
    } era_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [8:0]  yday;
        logic [23:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
    } date_t;

    // First day of each month counted from March 1st.
    function automatic logic [8:0] month_start(input logic [3:0] mi);
        logic [8:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ src/e2c_daysplit.sv @@
// Stages 1-5: biased seconds split into day count (rebased to 2000-03-01) and second of day.
// Depends on e2c_pkg.
module e2c_daysplit (
    input  logic                 aclk,
    input  e2c_pkg::stage_en_t   en,
    input  logic signed [47:0]   epoch_seconds,
    output logic [31:0]          dp,
    output logic [16:0]          sod
);
    import e2c_pkg::*;

    logic [48:0] u_reg;
    logic [53:0] pph_reg;
    logic [51:0] ppl_reg;
    logic [10:0] v2_reg;
    logic [6:0]  lo2_reg;
    logic [73:0] qsum;
    logic [31:0] qe3_reg;
    logic [10:0] v3_reg;
    logic [6:0]  lo3_reg;
    logic [10:0] qm;
    logic [31:0] qe4_reg;
    logic [10:0] r4_reg;
    logic [6:0]  lo4_reg;
    logic        fix;
    logic [10:0] rsel;
    logic [31:0] dp_reg;
    logic [16:0] sod_reg;

    assign qsum = {pph_reg, 20'b0} + 74'(ppl_reg);
    assign qm   = 11'(qe3_reg[10:0] * 11'(DIV_675));
    assign fix  = r4_reg >= 11'(DIV_675);
    assign rsel = fix ? r4_reg - 11'(DIV_675) : r4_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            u_reg <= {epoch_seconds[47], epoch_seconds} + EPOCH_OFFSET;
        end
        if (en[2]) begin
            pph_reg <= 54'(u_reg[48:27]) * 54'(RECIP_675);
            ppl_reg <= 52'(u_reg[26:7]) * 52'(RECIP_675);
            v2_reg  <= u_reg[17:7];
            lo2_reg <= u_reg[6:0];
        end
        if (en[3]) begin
            qe3_reg <= qsum[72:41];
            v3_reg  <= v2_reg;
            lo3_reg <= lo2_reg;
        end
        if (en[4]) begin
            qe4_reg <= qe3_reg;
            r4_reg  <= v3_reg - qm;
            lo4_reg <= lo3_reg;
        end
        if (en[5]) begin
            dp_reg  <= qe4_reg + 32'(fix) - 32'(REBASE_DAYS);
            sod_reg <= {rsel[9:0], lo4_reg};
        end
    end

    assign dp  = dp_reg;
    assign sod = sod_reg;

endmodule

@@ src/e2c_era.sv @@
// Stages 6-13: day count split into 400/100/4/1-year cycles plus weekday.
// Depends on e2c_pkg.
module e2c_era (
    input  logic                 aclk,
    input  e2c_pkg::stage_en_t   en,
    input  logic [31:0]          dp,
    output e2c_pkg::era_t        era
);
    import e2c_pkg::*;

    // stage 6
    logic [46:0] p400_reg;
    logic [18:0] dpl_reg;
    // stage 7
    logic [14:0] q400e_reg;
    logic [18:0] r7_reg;
    // stage 8
    logic        fix8;
    logic [18:0] r8sel;
    logic [14:0] q400_8_reg;
    logic [17:0] r400_reg;
    // stage 9
    logic [1:0]  c100;
    logic [5:0]  wsum1;
    logic [3:0]  wsum2;
    logic [14:0] q400_9_reg;
    logic [1:0]  c100_9_reg;
    logic [15:0] d100_9_reg;
    logic [2:0]  wday_9_reg;
    // stage 10
    logic [20:0] p4_reg;
    logic [14:0] q400_10_reg;
    logic [1:0]  c100_10_reg;
    logic [15:0] d100_10_reg;
    logic [2:0]  wday_10_reg;
    // stage 11
    logic [4:0]  q4e_reg;
    logic [11:0] r11_reg;
    logic [14:0] q400_11_reg;
    logic [1:0]  c100_11_reg;
    logic [2:0]  wday_11_reg;
    // stage 12
    logic        fix12;
    logic [11:0] r12sel;
    logic [4:0]  c4_12_reg;
    logic [10:0] d4_12_reg;
    logic [14:0] q400_12_reg;
    logic [1:0]  c100_12_reg;
    logic [2:0]  wday_12_reg;
    // stage 13
    logic [1:0]  c1;
    era_t        era_reg;

    assign fix8  = r7_reg >= 19'(D400);
    assign r8sel = fix8 ? r7_reg - 19'(D400) : r7_reg;

    assign c100 = 2'(r400_reg >= 18'd36524) + 2'(r400_reg >= 18'd73048)
                + 2'(r400_reg >= 18'd109572);

    // 8 == 1 mod 7: octal digit sums keep the residue
    assign wsum1 = ERA_WDAY + 6'(r400_reg[2:0]) + 6'(r400_reg[5:3]) + 6'(r400_reg[8:6])
                 + 6'(r400_reg[11:9]) + 6'(r400_reg[14:12]) + 6'(r400_reg[17:15]);
    assign wsum2 = 4'(wsum1[5:3]) + 4'(wsum1[2:0]);

    assign fix12  = r11_reg >= 12'(D4);
    assign r12sel = fix12 ? r11_reg - 12'(D4) : r11_reg;

    assign c1 = 2'(d4_12_reg >= 11'd365) + 2'(d4_12_reg >= 11'd730)
              + 2'(d4_12_reg >= 11'd1095);

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            p400_reg <= 47'(dp) * 47'(RECIP_D400);
            dpl_reg  <= dp[18:0];
        end
        if (en[7]) begin
            q400e_reg <= p400_reg[46:32];
            r7_reg    <= dpl_reg - 19'(19'(p400_reg[46:32]) * 19'(D400));
        end
        if (en[8]) begin
            q400_8_reg <= q400e_reg + 15'(fix8);
            r400_reg   <= r8sel[17:0];
        end
        if (en[9]) begin
            q400_9_reg <= q400_8_reg;
            c100_9_reg <= c100;
            d100_9_reg <= 16'(r400_reg - 18'(18'(c100) * 18'(D100)));
            wday_9_reg <= (wsum2 >= DAYS_PER_WEEK) ? 3'(wsum2 - DAYS_PER_WEEK) : 3'(wsum2);
        end
        if (en[10]) begin
            p4_reg      <= 21'(d100_9_reg) * 21'(RECIP_D4);
            q400_10_reg <= q400_9_reg;
            c100_10_reg <= c100_9_reg;
            d100_10_reg <= d100_9_reg;
            wday_10_reg <= wday_9_reg;
        end
        if (en[11]) begin
            q4e_reg     <= p4_reg[20:16];
            r11_reg     <= d100_10_reg[11:0] - 12'(12'(p4_reg[20:16]) * 12'(D4));
            q400_11_reg <= q400_10_reg;
            c100_11_reg <= c100_10_reg;
            wday_11_reg <= wday_10_reg;
        end
        if (en[12]) begin
            c4_12_reg   <= q4e_reg + 5'(fix12);
            d4_12_reg   <= r12sel[10:0];
            q400_12_reg <= q400_11_reg;
            c100_12_reg <= c100_11_reg;
            wday_12_reg <= wday_11_reg;
        end
        if (en[13]) begin
            era_reg.q400 <= q400_12_reg;
            era_reg.c100 <= c100_12_reg;
            era_reg.c4   <= c4_12_reg;
            era_reg.c1   <= c1;
            era_reg.d1   <= 9'(d4_12_reg - 11'(11'(c1) * 11'(D1)));
            era_reg.wday <= wday_12_reg;
        end
    end

    assign era = era_reg;

endmodule

@@ src/e2c_date.sv @@
// Stages 14-15: leap flag, year, day of year, month and day of month from the cycle counts.
// Depends on e2c_pkg.
module e2c_date (
    input  logic                 aclk,
    input  e2c_pkg::stage_en_t   en,
    input  e2c_pkg::era_t        era,
    output e2c_pkg::date_t       date
);
    import e2c_pkg::*;

    logic        leap;
    logic [3:0]  mi;
    logic        leap_reg;
    logic [23:0] year_reg;
    logic [3:0]  mi_reg;
    logic [8:0]  d1_reg;
    logic [2:0]  wday_reg;
    logic [8:0]  yday_pre;
    logic [8:0]  year_len;
    logic        wrap;
    date_t       date_reg;

    assign leap = (era.c1 == 2'd0) && ((era.c4 != 5'd0) || (era.c100 == 2'd0));

    always_comb begin
        mi = 4'd0;
        for (int k = 1; k < 12; k++) begin
            mi = mi + 4'(era.d1 >= month_start(4'(k)));
        end
    end

    assign yday_pre = d1_reg + MAR1_YDAY + 9'(leap_reg);
    assign year_len = D1 + 9'(leap_reg);
    assign wrap     = yday_pre >= year_len;

    always_ff @(posedge aclk) begin
        if (en[14]) begin
            leap_reg <= leap;
            year_reg <= 24'(era.q400) * ERA_YEARS - YEAR_BIAS
                      + 24'(era.c100) * CENTURY_YEARS
                      + 24'({era.c4, 2'b00}) + 24'(era.c1);
            mi_reg   <= mi;
            d1_reg   <= era.d1;
            wday_reg <= era.wday;
        end
        if (en[15]) begin
            date_reg.yday  <= wrap ? yday_pre - year_len : yday_pre;
            date_reg.year  <= year_reg + 24'(wrap);
            date_reg.month <= (mi_reg >= MONTH_WRAP) ? mi_reg - MONTH_WRAP
                                                     : mi_reg + MONTHS_TO_JAN;
            date_reg.mday  <= 5'(d1_reg - month_start(mi_reg) + 9'd1);
            date_reg.wday  <= wday_reg;
        end
    end

    assign date = date_reg;

endmodule

@@ src/e2c_clock.sv @@
// Stages 6-15: second of day split into hour, minute and second, then aligned to the date path.
// Depends on e2c_pkg.
module e2c_clock (
    input  logic                 aclk,
    input  e2c_pkg::stage_en_t   en,
    input  logic [16:0]          sod,
    output e2c_pkg::tod_t        tod
);
    import e2c_pkg::*;

    logic [28:0] ps_reg;
    logic [6:0]  sodl_reg;
    logic [10:0] mine_reg;
    logic [6:0]  sec7_reg;
    logic        fix8;
    logic [6:0]  sec8sel;
    logic [10:0] mins8_reg;
    logic [5:0]  sec8_reg;
    logic [15:0] ph_reg;
    logic [6:0]  mins9_reg;
    logic [5:0]  sec9_reg;
    logic [4:0]  hre_reg;
    logic [6:0]  min10_reg;
    logic [5:0]  sec10_reg;
    logic        fix11;
    logic [6:0]  min11sel;
    tod_t        tod11_reg;
    tod_t        dly_reg [12:15];

    assign fix8     = sec7_reg >= 7'(SIXTY);
    assign sec8sel  = fix8 ? sec7_reg - 7'(SIXTY) : sec7_reg;
    assign fix11    = min10_reg >= 7'(SIXTY);
    assign min11sel = fix11 ? min10_reg - 7'(SIXTY) : min10_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            ps_reg   <= 29'(sod) * 29'(RECIP_60_SOD);
            sodl_reg <= sod[6:0];
        end
        if (en[7]) begin
            mine_reg <= ps_reg[27:17];
            sec7_reg <= sodl_reg - 7'(7'(ps_reg[23:17]) * 7'(SIXTY));
        end
        if (en[8]) begin
            mins8_reg <= mine_reg + 11'(fix8);
            sec8_reg  <= sec8sel[5:0];
        end
        if (en[9]) begin
            ph_reg    <= 16'(mins8_reg) * 16'(RECIP_60_MOD);
            mins9_reg <= mins8_reg[6:0];
            sec9_reg  <= sec8_reg;
        end
        if (en[10]) begin
            hre_reg   <= ph_reg[15:11];
            min10_reg <= mins9_reg - 7'(7'(ph_reg[15:11]) * 7'(SIXTY));
            sec10_reg <= sec9_reg;
        end
        if (en[11]) begin
            tod11_reg.hour   <= hre_reg + 5'(fix11);
            tod11_reg.minute <= min11sel[5:0];
            tod11_reg.second <= sec10_reg;
        end
        if (en[12]) begin
            dly_reg[12] <= tod11_reg;
        end
        for (int k = 13; k <= 15; k++) begin
            if (en[k]) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign tod = dly_reg[15];

endmodule

@@ src/epoch_seconds_to_calendar.sv @@
// Signed Unix seconds to broken-down UTC Gregorian date and time of day.
// Top level: stage valid/enable chain; instantiates e2c_daysplit, e2c_era, e2c_clock, e2c_date.
//
// One result beat is produced for each accepted input beat; the block sustains one beat per
// clock while m_ready stays high. The constant divisions (by 86400, 146097, 1461 and 60) are
// each done as a reciprocal multiply, a remainder multiply and a one-step correction in
// successive stages. Each stage holds its beat while the next stage is full and stalled, so a
// stalled result only blocks the input once every stage is occupied. Any 48-bit signed input
// is valid; times before 1970 round down to the previous day, and the year is reported minus
// 1900 in 24-bit two's complement.
module epoch_seconds_to_calendar (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [47:0] s_epoch_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_second_of_minute,
    output logic [5:0]         m_minute_of_hour,
    output logic [4:0]         m_hour_of_day,
    output logic [2:0]         m_day_of_week,
    output logic [8:0]         m_day_of_year,
    output logic signed [23:0] m_year_since_1900,
    output logic [3:0]         m_month_index,
    output logic [4:0]         m_day_of_month
);
    import e2c_pkg::*;

    stage_en_t   en;
    stage_en_t   valid_reg;
    stage_en_t   valid_next;
    logic [31:0] dp;
    logic [16:0] sod;
    era_t        era;
    tod_t        tod;
    date_t       date;

    always_comb begin
        en[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (en[1]) begin
            valid_next[1] = s_valid;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    e2c_daysplit u_daysplit (
        .aclk          (aclk),
        .en            (en),
        .epoch_seconds (s_epoch_seconds),
        .dp            (dp),
        .sod           (sod)
    );

    e2c_era u_era (
        .aclk (aclk),
        .en   (en),
        .dp   (dp),
        .era  (era)
    );

    e2c_clock u_clock (
        .aclk (aclk),
        .en   (en),
        .sod  (sod),
        .tod  (tod)
    );

    e2c_date u_date (
        .aclk (aclk),
        .en   (en),
        .era  (era),
        .date (date)
    );

    assign s_ready            = en[1];
    assign m_valid            = valid_reg[NUM_STAGES];
    assign m_second_of_minute = tod.second;
    assign m_minute_of_hour   = tod.minute;
    assign m_hour_of_day      = tod.hour;
    assign m_day_of_week      = date.wday;
    assign m_day_of_year      = date.yday;
    assign m_year_since_1900  = $signed(date.year);
    assign m_month_index      = date.month;
    assign m_day_of_month     = date.mday;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[1])
        else $error("accepted beat missing from first stage");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_second_of_minute < 6'd60) && (m_minute_of_hour < 6'd60)
                    && (m_hour_of_day < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_of_week < 3'd7) && (m_month_index < 4'd12)
                    && (m_day_of_month != 5'd0) && (m_day_of_year < 9'd366))
        else $error("date field out of range");

endmodule
